FILE: design/lcrp_pkg.sv
// Shared types and constants for the LOOK / C-LOOK request picker.
// Used by the core and by its port checker; depends on nothing.
package lcrp_pkg;

  localparam int unsigned TRACK_W = 16;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_ADDED   = 2'd0;
  localparam status_t ST_DROPPED = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_CHOSEN  = 2'd3;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

endpackage

FILE: design/look_clook_request_picker_core.sv
// Top level of the LOOK / C-LOOK request picker: queue memory, scan sequencer, output register.
// Depends on lcrp_pkg.
//
// Usage:
//   Slave stream carries one command per request: tuser is the command (add or select),
//   tdata holds the request track and id (add) or the head track and direction (select).
//   Master stream returns one result per request: tuser is the status, tdata holds the
//   chosen id, chosen track and the number of requests still pending.
//   cfg_we_i with cfg_wdata_i sets the mode (0 LOOK, 1 C-LOOK); the user is to write it only
//   while the block is idle, which the block itself does not enforce.
// Sequencing:
//   An add, a dropped add or a select on an empty queue goes from accept to the result
//   state. A select with N pending requests whose pick sits at queue position k makes one
//   comparator pass over all N entries, read one per cycle from the queue memory's read
//   port, then a close-up pass from k to the tail through the read port and the write
//   port. One request is worked on at a time; tready is low from accept until the result
//   is handed to the output register.
// Reset:
//   The queue is empty and the mode is LOOK; the queue memory itself is not cleared.
// Stall:
//   The output register holds a result until tready; the next request may be accepted
//   meanwhile, and its result waits in the sequencer until the output register frees.
module look_clook_request_picker_core #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] request_track, [31:16] request_id, [47:32] head_track, [48] head_direction
  input  logic [lcrp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] chosen_id, [31:16] chosen_track, [37:32] pending_count
  output logic [lcrp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [lcrp_pkg::STAT_W-1:0]     m_axis_tuser
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW    = lcrp_pkg::TRACK_W;
  localparam int unsigned IW    = lcrp_pkg::ID_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  // queue memory
  logic [TW-1:0]    trk_mem [QUEUE_DEPTH];
  logic [IW-1:0]    id_mem  [QUEUE_DEPTH];
  logic [TW-1:0]    trk_rd_q;
  logic [IW-1:0]    id_rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [TW-1:0]    wr_trk;
  logic [IW-1:0]    wr_id;
  logic             wr_en;

  // sequencer
  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        ptr_q, ptr_d;
  logic                    vld_q, vld_d;
  logic [IDX_W-1:0]        didx_q, didx_d;
  logic                    circ_q, circ_d;
  logic [TW-1:0]           head_q, head_d;
  logic                    up_q, up_d;
  logic                    hit_found_q, hit_found_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic                    a_found_q, a_found_d;
  logic [TW-1:0]           a_key_q, a_key_d;
  logic [IDX_W-1:0]        a_idx_q, a_idx_d;
  logic                    b_found_q, b_found_d;
  logic [TW-1:0]           b_key_q, b_key_d;
  logic [IDX_W-1:0]        b_idx_q, b_idx_d;
  logic [IDX_W-1:0]        pick_q, pick_d;
  lcrp_pkg::status_t       res_st_q, res_st_d;
  logic [TW-1:0]           res_trk_q, res_trk_d;
  logic [IW-1:0]           res_id_q, res_id_d;
  logic                    m_valid_q, m_valid_d;
  lcrp_pkg::status_t       m_st_q, m_st_d;
  logic [TW-1:0]           m_trk_q, m_trk_d;
  logic [IW-1:0]           m_id_q, m_id_d;
  logic [lcrp_pkg::COUNT_W-1:0] m_cnt_q, m_cnt_d;

  // shared compare unit
  logic [TW-1:0]    t;
  logic             is_up;
  logic             is_hit;
  logic [TW-1:0]    trk_gap;
  logic             a_cond;
  logic [TW-1:0]    b_key;
  logic             issue;
  logic [IDX_W-1:0] pick_idx;

  logic [TW-1:0] in_trk;
  logic [IW-1:0] in_id;
  logic [TW-1:0] in_head;
  logic          in_dir;
  logic          in_acc;

  assign in_trk  = s_axis_tdata[TW-1:0];
  assign in_id   = s_axis_tdata[TW+IW-1:TW];
  assign in_head = s_axis_tdata[2*TW+IW-1:TW+IW];
  assign in_dir  = s_axis_tdata[2*TW+IW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign t       = trk_rd_q;
  assign is_up   = t > head_q;
  assign is_hit  = t == head_q;
  assign trk_gap = is_up ? (t - head_q) : (head_q - t);
  assign a_cond  = circ_q ? is_up : (up_q ? is_up : !is_up);
  assign b_key   = circ_q ? t : trk_gap;
  assign issue   = ptr_q < cnt_q;
  assign rd_addr = ptr_q[IDX_W-1:0];
  assign pick_idx = hit_found_q ? hit_idx_q : (a_found_q ? a_idx_q : b_idx_q);

  always_ff @(posedge clk_i) begin
    trk_rd_q <= trk_mem[rd_addr];
    id_rd_q  <= id_mem[rd_addr];
    if (wr_en) begin
      trk_mem[wr_addr] <= wr_trk;
      id_mem[wr_addr]  <= wr_id;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    vld_d       = 1'b0;
    didx_d      = didx_q;
    circ_d      = cfg_we_i ? cfg_wdata_i : circ_q;
    head_d      = head_q;
    up_d        = up_q;
    hit_found_d = hit_found_q;
    hit_idx_d   = hit_idx_q;
    a_found_d   = a_found_q;
    a_key_d     = a_key_q;
    a_idx_d     = a_idx_q;
    b_found_d   = b_found_q;
    b_key_d     = b_key_q;
    b_idx_d     = b_idx_q;
    pick_d      = pick_q;
    res_st_d    = res_st_q;
    res_trk_d   = res_trk_q;
    res_id_d    = res_id_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_st_d      = m_st_q;
    m_trk_d     = m_trk_q;
    m_id_d      = m_id_q;
    m_cnt_d     = m_cnt_q;
    wr_en       = 1'b0;
    wr_addr     = cnt_q[IDX_W-1:0];
    wr_trk      = in_trk;
    wr_id       = in_id;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_trk_d = '0;
          res_id_d  = '0;
          state_d   = S_RESP;
          if (s_axis_tuser == lcrp_pkg::CMD_ADD) begin
            if (cnt_q == FULL_CNT) begin
              res_st_d = lcrp_pkg::ST_DROPPED;
            end else begin
              wr_en    = 1'b1;
              cnt_d    = cnt_q + 1'b1;
              res_st_d = lcrp_pkg::ST_ADDED;
            end
          end else if (cnt_q == '0) begin
            res_st_d = lcrp_pkg::ST_EMPTY;
          end else begin
            head_d      = in_head;
            up_d        = in_dir;
            ptr_d       = '0;
            hit_found_d = 1'b0;
            a_found_d   = 1'b0;
            b_found_d   = 1'b0;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          vld_d  = 1'b1;
          didx_d = ptr_q[IDX_W-1:0];
          ptr_d  = ptr_q + 1'b1;
        end
        if (vld_q) begin
          if (is_hit && !hit_found_q) begin
            hit_found_d = 1'b1;
            hit_idx_d   = didx_q;
          end
          if (a_cond && (!a_found_q || trk_gap < a_key_q)) begin
            a_found_d = 1'b1;
            a_key_d   = trk_gap;
            a_idx_d   = didx_q;
          end
          if (!b_found_q || b_key < b_key_q) begin
            b_found_d = 1'b1;
            b_key_d   = b_key;
            b_idx_d   = didx_q;
          end
        end else if (!issue) begin
          pick_d  = pick_idx;
          ptr_d   = CNT_W'(pick_idx);
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (issue) begin
          vld_d  = 1'b1;
          didx_d = ptr_q[IDX_W-1:0];
          ptr_d  = ptr_q + 1'b1;
        end
        wr_addr = didx_q - 1'b1;
        wr_trk  = trk_rd_q;
        wr_id   = id_rd_q;
        if (vld_q) begin
          if (didx_q == pick_q) begin
            res_trk_d = trk_rd_q;
            res_id_d  = id_rd_q;
          end else begin
            wr_en = 1'b1;
          end
        end else if (!issue) begin
          cnt_d    = cnt_q - 1'b1;
          res_st_d = lcrp_pkg::ST_CHOSEN;
          state_d  = S_RESP;
        end
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_st_d    = res_st_q;
          m_trk_d   = res_trk_q;
          m_id_d    = res_id_q;
          m_cnt_d   = lcrp_pkg::COUNT_W'(cnt_q);
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      vld_q       <= 1'b0;
      didx_q      <= '0;
      circ_q      <= 1'b0;
      head_q      <= '0;
      up_q        <= 1'b0;
      hit_found_q <= 1'b0;
      hit_idx_q   <= '0;
      a_found_q   <= 1'b0;
      a_key_q     <= '0;
      a_idx_q     <= '0;
      b_found_q   <= 1'b0;
      b_key_q     <= '0;
      b_idx_q     <= '0;
      pick_q      <= '0;
      res_st_q    <= lcrp_pkg::ST_ADDED;
      res_trk_q   <= '0;
      res_id_q    <= '0;
      m_valid_q   <= 1'b0;
      m_st_q      <= lcrp_pkg::ST_ADDED;
      m_trk_q     <= '0;
      m_id_q      <= '0;
      m_cnt_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      vld_q       <= vld_d;
      didx_q      <= didx_d;
      circ_q      <= circ_d;
      head_q      <= head_d;
      up_q        <= up_d;
      hit_found_q <= hit_found_d;
      hit_idx_q   <= hit_idx_d;
      a_found_q   <= a_found_d;
      a_key_q     <= a_key_d;
      a_idx_q     <= a_idx_d;
      b_found_q   <= b_found_d;
      b_key_q     <= b_key_d;
      b_idx_q     <= b_idx_d;
      pick_q      <= pick_d;
      res_st_q    <= res_st_d;
      res_trk_q   <= res_trk_d;
      res_id_q    <= res_id_d;
      m_valid_q   <= m_valid_d;
      m_st_q      <= m_st_d;
      m_trk_q     <= m_trk_d;
      m_id_q      <= m_id_d;
      m_cnt_q     <= m_cnt_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_st_q;
  assign m_axis_tdata  = {2'b00, m_cnt_q, m_trk_q, m_id_q};

endmodule

FILE: design/lcrp_checker.sv
// Port-level checker for the request picker core, bound to every instance.
// Depends on lcrp_pkg and look_clook_request_picker_core.
module lcrp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lcrp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [lcrp_pkg::STAT_W-1:0]     m_axis_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // drop ready after every accepted request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after accept");

  // empty select reports no pending requests
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == lcrp_pkg::ST_EMPTY |-> m_axis_tdata[37:32] == '0)
    else $error("empty status with pending requests");

  // zero id and track unless a request was chosen
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != lcrp_pkg::ST_CHOSEN |-> m_axis_tdata[31:0] == '0)
    else $error("nonzero id or track without a chosen request");

endmodule

bind look_clook_request_picker_core lcrp_checker u_lcrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
